// File: sv/keyed_rotate_block_cipher16_defines.svh
// Assertion macros used by the checker of the keyed rotate cipher.
`ifndef KEYED_ROTATE_BLOCK_CIPHER16_DEFINES_SVH
`define KEYED_ROTATE_BLOCK_CIPHER16_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KRBC16_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("krbc16 check failed");

// The consequent must hold in the cycle after the antecedent.
`define KRBC16_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("krbc16 check failed");

`endif

// File: sv/krbc16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krbc16_pkg;

   localparam int BLOCK_W = 16;
   localparam int KEY_W   = 64;
   localparam int BYTE_W  = 8;
   localparam int SEL_W   = 3;

   // Direction code carried by req_type.
   typedef enum logic {
      DIR_ENCRYPT = 1'b0,
      DIR_DECRYPT = 1'b1
   } dir_type;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [KEY_W-1:0]   key_type;

   // Key byte picked by the low three block bits, placed in the high byte.
   function automatic block_type key_byte_hi(input key_type key, input block_type blk);
      logic [SEL_W-1:0] sel;
      sel = blk[SEL_W-1:0];
      return {key[BYTE_W*sel +: BYTE_W], {BYTE_W{1'b0}}};
   endfunction

endpackage

`default_nettype wire

// File: sv/krbc16_round.sv
`timescale 1ns / 1ps
`default_nettype none

module krbc16_round (
   input  wire krbc16_pkg::dir_type   dir,
   input  wire krbc16_pkg::key_type   key,
   input  wire krbc16_pkg::block_type blk_i,
   output krbc16_pkg::block_type      blk_o
);

   krbc16_pkg::block_type mixed;
   krbc16_pkg::block_type rot_left;

   // Encrypt mixes the key byte in and then rotates right by one.
   assign mixed = blk_i ^ krbc16_pkg::key_byte_hi(key, blk_i);

   // Decrypt rotates left by one and then mixes the key byte in.
   assign rot_left = {blk_i[krbc16_pkg::BLOCK_W-2:0], blk_i[krbc16_pkg::BLOCK_W-1]};

   always_comb begin
      unique case (dir)
         krbc16_pkg::DIR_ENCRYPT: begin
            blk_o = {mixed[0], mixed[krbc16_pkg::BLOCK_W-1:1]};
         end
         krbc16_pkg::DIR_DECRYPT: begin
            blk_o = rot_left ^ krbc16_pkg::key_byte_hi(key, rot_left);
         end
         default: begin
            blk_o = blk_i;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/krbc16_core.sv
`timescale 1ns / 1ps
`default_nettype none

module krbc16_core #(
   parameter int ROUND_COUNT = 16
) (
   input  wire krbc16_pkg::dir_type   dir,
   input  wire krbc16_pkg::key_type   key,
   input  wire krbc16_pkg::block_type blk_i,
   output krbc16_pkg::block_type      blk_o
);

   krbc16_pkg::block_type chain [0:ROUND_COUNT];

   assign chain[0] = blk_i;

   // One round cell per round, chained from the input to the output.
   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      krbc16_round u_round (
         .dir   (dir),
         .key   (key),
         .blk_i (chain[r]),
         .blk_o (chain[r+1])
      );
   end

   assign blk_o = chain[ROUND_COUNT];

endmodule

`default_nettype wire

// File: sv/keyed_rotate_block_cipher16.sv
`timescale 1ns / 1ps
`default_nettype none

// Keyed rotate cipher on 16-bit blocks under a 64-bit key.
// Request channel: raise start with req_type (0 encrypt, 1 decrypt) and
// req_block_in; a beat is taken at each clock edge where start is high and
// busy is low. Busy is low at all times except during reset, so a new beat
// may be issued in every cycle.
// Result channel: rsp_valid is high for one cycle with rsp_block_out. A
// taken beat is held in the input register, passes the round chain and is
// captured in the result register; throughput is one block per cycle. The
// receiver cannot stall; it must take each result in the cycle it is shown.
// Key port: csr_data is written to the key register when csr_valid and
// csr_ready are both high; csr_ready is always high. Change the key only
// while no block is in flight.
// All rounds run as one chain of round cells between the input register and
// the result register, so the round count sets the depth of that path.
// Synchronous reset clears the key to zero and drops all in-flight beats.
module keyed_rotate_block_cipher16 #(
   parameter int ROUND_COUNT = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   input  wire        req_type,
   input  wire [15:0] req_block_in,
   output logic       rsp_valid,
   output logic [15:0] rsp_block_out,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [63:0] csr_data
);

   krbc16_pkg::key_type   key_ff;
   krbc16_pkg::key_type   key_in;
   logic                  vld_ff;
   logic                  vld_in;
   krbc16_pkg::dir_type   dir_ff;
   krbc16_pkg::block_type blk_ff;
   logic                  rsp_vld_ff;
   krbc16_pkg::block_type rsp_blk_ff;
   krbc16_pkg::block_type core_out;

   // The block can always take a beat once out of reset.
   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign vld_in    = start && !busy;
   assign key_in    = (csr_valid && csr_ready) ? csr_data : key_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         vld_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         key_ff     <= key_in;
         vld_ff     <= vld_in;
         rsp_vld_ff <= vld_ff;
      end
   end

   // Payload registers at the input and the result.
   always_ff @(posedge clock) begin
      if (vld_in) begin
         dir_ff <= krbc16_pkg::dir_type'(req_type);
         blk_ff <= req_block_in;
      end
      if (vld_ff) begin
         rsp_blk_ff <= core_out;
      end
   end

   krbc16_core #(
      .ROUND_COUNT (ROUND_COUNT)
   ) u_core (
      .dir   (dir_ff),
      .key   (key_ff),
      .blk_i (blk_ff),
      .blk_o (core_out)
   );

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_block_out = rsp_blk_ff;

endmodule

`default_nettype wire

// File: sv/krbc16_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_rotate_block_cipher16_defines.svh"

module krbc16_checker (
   input wire        clock,
   input wire        reset,
   input wire        start,
   input wire        busy,
   input wire        rsp_valid
);

   logic accepted;

   assign accepted = start && !busy;

   // Every accepted beat yields a result once it has passed the input and result registers.
   `KRBC16_ASSERT_NOW(a_beat_gives_result, clock, reset, $past(accepted, 2) && !$past(reset, 1), rsp_valid)

   // A result never shows up without an accepted beat ahead of it.
   `KRBC16_ASSERT_NOW(a_no_invented_result, clock, reset, rsp_valid, $past(accepted, 2))

   // Out of reset the block never refuses a beat.
   `KRBC16_ASSERT_NEXT(a_never_busy, clock, reset, 1'b1, !busy)

endmodule

bind keyed_rotate_block_cipher16 krbc16_checker u_krbc16_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid)
);

`default_nettype wire

// File: tb/sv/tb_keyed_rotate_block_cipher16.sv
`timescale 1ns / 1ps

module tb_keyed_rotate_block_cipher16;

   localparam int ROUNDS      = 16;
   localparam int SETTLE      = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;
   localparam int PHASE_ITEMS = 315;

   // One request beat: direction and block.
   typedef struct {
      krbc16_pkg::dir_type   dir;
      krbc16_pkg::block_type blk;
   } cipher_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = 1'b0;
   logic [15:0] req_block_in = '0;
   logic        rsp_valid;
   logic [15:0] rsp_block_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_data = '0;

   cipher_req_type        req_backlog[$];
   krbc16_pkg::block_type blocks_due[$];
   krbc16_pkg::key_type   key_shadow;
   int                    idle_pct = 0;
   int                    fail_count = 0;
   int                    cycle_count = 0;

   keyed_rotate_block_cipher16 #(
      .ROUND_COUNT(ROUNDS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_block_in (req_block_in),
      .rsp_valid    (rsp_valid),
      .rsp_block_out(rsp_block_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Runs all rounds of one direction on a block under the given key.
   function automatic krbc16_pkg::block_type cipher_rounds(
      input krbc16_pkg::dir_type   dir,
      input krbc16_pkg::block_type blk,
      input krbc16_pkg::key_type   key);
      krbc16_pkg::block_type b;
      logic [2:0]            sel;
      b = blk;
      for (int r = 0; r < ROUNDS; r++) begin
         if (dir == krbc16_pkg::DIR_ENCRYPT) begin
            sel = b[2:0];
            b[15:8] = b[15:8] ^ key[8*sel +: 8];
            b = {b[0], b[15:1]};
         end else begin
            b = {b[14:0], b[15]};
            sel = b[2:0];
            b[15:8] = b[15:8] ^ key[8*sel +: 8];
         end
      end
      return b;
   endfunction

   function automatic void flag_error(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("ERROR @%0d: %s", cycle_count, msg);
      end
   endfunction

   // Shadow copy of the key register, updated on each accepted key beat.
   always @(posedge clock) begin
      if (reset) begin
         key_shadow <= '0;
      end else if (csr_valid && csr_ready) begin
         key_shadow <= csr_data;
      end
   end

   // Request driver: predicts each accepted beat and presents the next one.
   always @(posedge clock) begin
      cipher_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            blocks_due.push_back(cipher_rounds(krbc16_pkg::dir_type'(req_type),
                                               req_block_in, key_shadow));
         end
         if (!start || !busy) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = req_backlog.pop_front();
               start <= 1'b1;
               req_type <= nxt.dir;
               req_block_in <= nxt.blk;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every strobed result must match the oldest prediction.
   always @(posedge clock) begin
      krbc16_pkg::block_type want;
      if (!reset && rsp_valid) begin
         if (blocks_due.size() == 0) begin
            flag_error($sformatf("unexpected result %h", rsp_block_out));
         end else begin
            want = blocks_due.pop_front();
            if (rsp_block_out !== want) begin
               flag_error($sformatf("block_out expected %h got %h", want, rsp_block_out));
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_keyed_rotate_block_cipher16: errors");
         $finish;
      end
   end

   function automatic void queue_req(input krbc16_pkg::dir_type dir,
                                     input krbc16_pkg::block_type blk);
      cipher_req_type it;
      it.dir = dir;
      it.blk = blk;
      req_backlog.push_back(it);
   endfunction

   function automatic void queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         queue_req(krbc16_pkg::dir_type'($urandom_range(1)),
                   krbc16_pkg::block_type'($urandom));
      end
   endfunction

   // Holds the sender back until every beat has been taken and answered.
   task automatic drain_all();
      while (req_backlog.size() != 0 || start || blocks_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_key(input krbc16_pkg::key_type k);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      krbc16_pkg::block_type edge_blocks[6];
      krbc16_pkg::key_type   phase_keys[6];
      edge_blocks = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme blocks in both directions under the reset key.
      idle_pct = 34;
      foreach (edge_blocks[i]) begin
         queue_req(krbc16_pkg::DIR_ENCRYPT, edge_blocks[i]);
         queue_req(krbc16_pkg::DIR_DECRYPT, edge_blocks[i]);
      end
      drain_all();

      // Directed: all-ones key.
      load_key('1);
      queue_req(krbc16_pkg::DIR_ENCRYPT, 16'h0000);
      queue_req(krbc16_pkg::DIR_DECRYPT, 16'h0000);
      queue_req(krbc16_pkg::DIR_ENCRYPT, 16'hFFFF);
      queue_req(krbc16_pkg::DIR_DECRYPT, 16'hFFFF);
      drain_all();

      // Directed: distinct key bytes, each byte selected first once by an encrypt beat, then one decrypt beat.
      load_key(64'h8040_2010_0804_0201);
      for (int s = 0; s < 8; s++) begin
         queue_req(krbc16_pkg::DIR_ENCRYPT, krbc16_pkg::block_type'(16'hA5A0 | s));
      end
      queue_req(krbc16_pkg::DIR_DECRYPT, 16'h5A5F);
      drain_all();

      // Random phases, each under its own key; the sender pauses between them.
      phase_keys[0] = {$urandom, $urandom};
      phase_keys[1] = '1;
      phase_keys[2] = {$urandom, $urandom};
      phase_keys[3] = '0;
      phase_keys[4] = {$urandom, $urandom};
      phase_keys[5] = {32'h0F0F_F0F0, $urandom};
      for (int p = 0; p < 6; p++) begin
         idle_pct = (p < 2) ? 34 : (p < 4) ? 69 : 0;
         load_key(phase_keys[p]);
         queue_random(PHASE_ITEMS);
         drain_all();
      end

      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_keyed_rotate_block_cipher16: clean");
      end else begin
         $display("tb_keyed_rotate_block_cipher16: errors");
      end
      $finish;
   end

endmodule
